### src/h2r_pkg.sv
// Shared types and constants for the HSL to RGB converter.
// No dependencies; used by h2r_channel and hsl_to_rgb_converter_core.
`timescale 1ns / 1ps

package h2r_pkg;

	// Hue scale in 1/16 degree steps.
	localparam int unsigned HUE_FULL  = 5760;
	localparam int unsigned HUE_THIRD = 1920;
	localparam int unsigned HUE_TWO   = 3840;
	localparam int unsigned HUE_SIXTH = 960;

	// Q1.8 unit and half, and the full scale of a mixed channel value (256 * 960).
	localparam int unsigned UNIT_Q8   = 256;
	localparam int unsigned HALF_Q8   = 128;
	localparam int unsigned MIX_SCALE = 245760;

	// The output scale 255 / (256 * 245760) reduces to 17 / 2^22.
	localparam int unsigned OUT_MUL   = 17;
	localparam int unsigned OUT_SHIFT = 22;
	localparam logic [7:0]  LEVEL_MAX = 8'd255;

	typedef logic [12:0]        hue_t;
	typedef logic [8:0]         q18_t;
	typedef logic [9:0]         weight_t;
	typedef logic signed [9:0]  lmul_t;
	typedef logic signed [21:0] mix_t;
	typedef logic signed [31:0] acc_t;
	typedef logic [7:0]         level_t;

	// Stage advance enables for the per-channel datapath.
	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} h2r_adv_t;

endpackage

### src/h2r_channel.sv
// One color channel of the converter: saturation mix, lightness mix and output scaling.
// Depends on h2r_pkg; instantiated three times by hsl_to_rgb_converter_core.
`timescale 1ns / 1ps

module h2r_channel (
	input  logic              clk,
	input  h2r_pkg::h2r_adv_t adv,
	input  h2r_pkg::q18_t     sat_s2,
	input  h2r_pkg::weight_t  weight_s2,
	input  h2r_pkg::mix_t     base_s2,
	input  h2r_pkg::lmul_t    lmul_s3,
	input  h2r_pkg::acc_t     offset_s3,
	output h2r_pkg::level_t   level
);

	logic [18:0]          sn;
	h2r_pkg::mix_t        c_next;
	h2r_pkg::mix_t        c_s3;
	h2r_pkg::acc_t        lc;
	h2r_pkg::acc_t        x_next;
	h2r_pkg::acc_t        x_s4;
	logic signed [36:0]   p;
	h2r_pkg::level_t      level_next;
	h2r_pkg::level_t      level_s5;

	// Saturation mix: C = 2*S*n + (256 - S)*960.
	assign sn     = 19'(sat_s2) * 19'(weight_s2);
	assign c_next = $signed({2'b00, sn, 1'b0}) + base_s2;

	// Lightness mix: X = lmul * C + offset.
	assign lc     = 32'(lmul_s3) * 32'(c_s3);
	assign x_next = lc + offset_s3;

	// Scale by 17 / 2^22, truncate, and saturate to the 8-bit range.
	assign p = (37'(x_s4) <<< 4) + 37'(x_s4);

	always_comb begin
		if (p[36] || (p == 37'sd0)) begin
			level_next = '0;
		end else if (p[36:30] != 7'd0) begin
			level_next = h2r_pkg::LEVEL_MAX;
		end else begin
			level_next = p[29:22];
		end
	end

	// Pipeline registers for stages three to five.
	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			c_s3 <= c_next;
		end
		if (adv.en_s4) begin
			x_s4 <= x_next;
		end
		if (adv.en_s5) begin
			level_s5 <= level_next;
		end
	end

	assign level = level_s5;

endmodule

### src/hsl_to_rgb_converter_core.sv
// Top level of the HSL to RGB converter: hue wrap, sector weights and stage control.
// Depends on h2r_pkg and h2r_channel.
//
// Channel   Valid       Stall       Word
// input     hsl_valid   hsl_stall   hue, saturation, lightness
// output    rgb_valid   rgb_stall   red_level, green_level, blue_level
//
// One word can enter every cycle, unless rgb_stall holds the output while every stage is occupied.
// The stages are hue wrap, sector weights, saturation multiply, lightness multiply, scaling.
// Each stage advances when it is empty or the stage after it advances, so bubbles close up.
// rgb_stall holds the output word; hsl_stall rises only when every stage is occupied.
// arst_n clears the stage valid bits; data registers are not reset.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            hsl_valid,
	output logic            hsl_stall,
	input  h2r_pkg::hue_t   hue,
	input  h2r_pkg::q18_t   saturation,
	input  h2r_pkg::q18_t   lightness,
	output logic            rgb_valid,
	input  logic            rgb_stall,
	output h2r_pkg::level_t red_level,
	output h2r_pkg::level_t green_level,
	output h2r_pkg::level_t blue_level
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2;
	h2r_pkg::h2r_adv_t adv;

	h2r_pkg::hue_t    hue_next;
	h2r_pkg::hue_t    hue_s1;
	h2r_pkg::q18_t    sat_s1, lit_s1;

	h2r_pkg::hue_t    raw_r, raw_g, raw_b;
	h2r_pkg::weight_t wr_s2, wg_s2, wb_s2;
	h2r_pkg::q18_t    sat_s2;
	logic signed [10:0] sdiff;
	h2r_pkg::mix_t    base_next, base_s2;
	h2r_pkg::lmul_t   lmul_next, lmul_s2, lmul_s3;
	logic [9:0]       ltwo;
	h2r_pkg::acc_t    offset_next, offset_s2, offset_s3;

	function automatic h2r_pkg::weight_t clamp_weight(input h2r_pkg::hue_t x);
		if (x > 13'(h2r_pkg::HUE_SIXTH)) begin
			return 10'(h2r_pkg::HUE_SIXTH);
		end
		return x[9:0];
	endfunction

	// Stage enables: a stage moves when it is empty or its successor moves.
	assign adv.en_s5 = !v_s5 || !rgb_stall;
	assign adv.en_s4 = !v_s4 || adv.en_s5;
	assign adv.en_s3 = !v_s3 || adv.en_s4;
	assign en_s2     = !v_s2 || adv.en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign hsl_stall = !en_s1;
	assign rgb_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= hsl_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (adv.en_s3) begin
				v_s3 <= v_s2;
			end
			if (adv.en_s4) begin
				v_s4 <= v_s3;
			end
			if (adv.en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// Stage one: bring a hue above the full circle back into range.
	assign hue_next = (hue > 13'(h2r_pkg::HUE_FULL)) ? (hue - 13'(h2r_pkg::HUE_FULL)) : hue;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			hue_s1 <= hue_next;
			sat_s1 <= saturation;
			lit_s1 <= lightness;
		end
	end

	// Stage two: sector weights before clamping.
	always_comb begin
		if (hue_s1 < 13'(h2r_pkg::HUE_THIRD)) begin
			raw_r = 13'(h2r_pkg::HUE_THIRD) - hue_s1;
			raw_g = hue_s1;
			raw_b = '0;
		end else if (hue_s1 < 13'(h2r_pkg::HUE_TWO)) begin
			raw_r = '0;
			raw_g = 13'(h2r_pkg::HUE_TWO) - hue_s1;
			raw_b = hue_s1 - 13'(h2r_pkg::HUE_THIRD);
		end else begin
			raw_r = hue_s1 - 13'(h2r_pkg::HUE_TWO);
			raw_g = '0;
			raw_b = 13'(h2r_pkg::HUE_FULL) - hue_s1;
		end
	end

	// Stage two: grey term of the saturation mix and the lightness factors.
	assign sdiff     = 11'(h2r_pkg::UNIT_Q8) - $signed({2'b00, sat_s1});
	assign base_next = 22'(sdiff) * 22'(h2r_pkg::HUE_SIXTH);
	assign ltwo      = {lit_s1, 1'b0} - 10'(h2r_pkg::UNIT_Q8);

	always_comb begin
		if (lit_s1 < 9'(h2r_pkg::HALF_Q8)) begin
			lmul_next   = $signed({1'b0, lit_s1});
			offset_next = '0;
		end else begin
			lmul_next   = 10'(h2r_pkg::UNIT_Q8) - $signed({1'b0, lit_s1});
			offset_next = $signed(32'(ltwo) * 32'(h2r_pkg::MIX_SCALE));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			wr_s2     <= clamp_weight(raw_r);
			wg_s2     <= clamp_weight(raw_g);
			wb_s2     <= clamp_weight(raw_b);
			sat_s2    <= sat_s1;
			base_s2   <= base_next;
			lmul_s2   <= lmul_next;
			offset_s2 <= offset_next;
		end
		if (adv.en_s3) begin
			lmul_s3   <= lmul_s2;
			offset_s3 <= offset_s2;
		end
	end

	// Stages three to five, one datapath per color.
	h2r_channel u_red (
		.clk       (clk),
		.adv       (adv),
		.sat_s2    (sat_s2),
		.weight_s2 (wr_s2),
		.base_s2   (base_s2),
		.lmul_s3   (lmul_s3),
		.offset_s3 (offset_s3),
		.level     (red_level)
	);

	h2r_channel u_green (
		.clk       (clk),
		.adv       (adv),
		.sat_s2    (sat_s2),
		.weight_s2 (wg_s2),
		.base_s2   (base_s2),
		.lmul_s3   (lmul_s3),
		.offset_s3 (offset_s3),
		.level     (green_level)
	);

	h2r_channel u_blue (
		.clk       (clk),
		.adv       (adv),
		.sat_s2    (sat_s2),
		.weight_s2 (wb_s2),
		.base_s2   (base_s2),
		.lmul_s3   (lmul_s3),
		.offset_s3 (offset_s3),
		.level     (blue_level)
	);

`ifndef SYNTHESIS
	// Input is refused only when every stage holds a word and the output is held.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && rgb_stall))
		else $error("input stalled while the pipeline has room");

	// At most two sector weights are nonzero in any hue.
	a_two_weights: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (wr_s2 == 10'd0 || wg_s2 == 10'd0 || wb_s2 == 10'd0))
		else $error("three nonzero sector weights");

	// Weights never exceed the 60 degree span.
	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (wr_s2 <= 10'd960 && wg_s2 <= 10'd960 && wb_s2 <= 10'd960))
		else $error("sector weight above one");

	// A held output word keeps its valid bit into the next cycle.
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && rgb_stall) |=> (v_s5 && $stable(red_level) && $stable(blue_level)))
		else $error("stalled output word lost");
`endif

endmodule

### tb/sv/hsl_to_rgb_converter_core_tb.sv
// Self-checking testbench for hsl_to_rgb_converter_core: random and edge-case HSL words in,
// predicted 8-bit RGB levels compared word by word. Depends on h2r_pkg and the core RTL.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_core_tb;

	import h2r_pkg::*;

	localparam int RandomWords  = 2000;
	localparam int TailWords    = 200;
	localparam int CycleLimit   = 400000;
	localparam int DrainCycles  = 20;
	localparam int ReportLimit  = 10;

	// Signed copies of the package scales so the predictor can go negative.
	localparam longint HueFull  = HUE_FULL;
	localparam longint HueThird = HUE_THIRD;
	localparam longint HueTwo   = HUE_TWO;
	localparam longint HueSixth = HUE_SIXTH;
	localparam longint UnitQ8   = UNIT_Q8;
	localparam longint HalfQ8   = HALF_Q8;
	localparam longint MixFull  = MIX_SCALE;

	typedef struct {
		hue_t hue;
		q18_t saturation;
		q18_t lightness;
	} hsl_word_t;

	typedef struct {
		level_t red;
		level_t green;
		level_t blue;
	} rgb_word_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   hsl_valid = 1'b0;
	logic   hsl_stall;
	hue_t   hue = '0;
	q18_t   saturation = '0;
	q18_t   lightness = '0;
	logic   rgb_valid;
	logic   rgb_stall = 1'b0;
	level_t red_level;
	level_t green_level;
	level_t blue_level;

	hsl_word_t hsl_pending[$];
	rgb_word_t rgb_expected[$];
	hsl_word_t next_word;
	rgb_word_t seen_rgb;
	rgb_word_t want_rgb;
	int        send_gap = 0;
	int        recv_hold = 0;
	int        mismatch_count = 0;
	int        cycle_count = 0;

	hsl_to_rgb_converter_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.hsl_valid   (hsl_valid),
		.hsl_stall   (hsl_stall),
		.hue         (hue),
		.saturation  (saturation),
		.lightness   (lightness),
		.rgb_valid   (rgb_valid),
		.rgb_stall   (rgb_stall),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level)
	);

	// Free-running clock.
	initial begin
		forever #6 clk = ~clk;
	end

	// Sector weight limited to the range 0..1 (960 stands for 1.0).
	function automatic longint clamp_weight(longint n);
		if (n < 0)
			return 0;
		if (n > HueSixth)
			return HueSixth;
		return n;
	endfunction

	// One channel: mix the weight with saturation, apply lightness, scale to 0..255.
	function automatic level_t weight_to_level(longint n, longint s, longint l);
		longint mix;
		longint num;
		longint q;
		mix = 2 * s * n + (UnitQ8 - s) * HueSixth;
		if (l < HalfQ8)
			num = 255 * l * mix;
		else
			num = 255 * ((UnitQ8 - l) * mix + (2 * l - UnitQ8) * MixFull);
		if (num <= 0)
			return '0;
		q = num / (UnitQ8 * MixFull);
		if (q > 255)
			return LEVEL_MAX;
		return level_t'(q);
	endfunction

	// Full conversion of one HSL word into the RGB word the core should produce.
	function automatic rgb_word_t hsl_to_levels(hsl_word_t w);
		longint    h;
		longint    wr;
		longint    wg;
		longint    wb;
		rgb_word_t r;
		h = w.hue;
		// A hue past the full circle wraps once; exactly 5760 stays in the last sector.
		if (h > HueFull)
			h = h - HueFull;
		if (h < HueThird) begin
			wr = HueThird - h;
			wg = h;
			wb = 0;
		end else if (h < HueTwo) begin
			wr = 0;
			wg = HueTwo - h;
			wb = h - HueThird;
		end else begin
			wr = h - HueTwo;
			wg = 0;
			wb = HueFull - h;
		end
		r.red   = weight_to_level(clamp_weight(wr), w.saturation, w.lightness);
		r.green = weight_to_level(clamp_weight(wg), w.saturation, w.lightness);
		r.blue  = weight_to_level(clamp_weight(wb), w.saturation, w.lightness);
		return r;
	endfunction

	task automatic queue_hsl(int h, int s, int l);
		hsl_word_t w;
		w.hue        = hue_t'(h);
		w.saturation = q18_t'(s);
		w.lightness  = q18_t'(l);
		hsl_pending.push_back(w);
	endtask

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= ReportLimit)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Hue values around the sector and clamp boundaries, and the wrap point.
	function automatic int hue_edge();
		case ($urandom_range(0, 11))
			0:       return 0;
			1:       return HUE_SIXTH - 1;
			2:       return HUE_SIXTH;
			3:       return HUE_THIRD - 1;
			4:       return HUE_THIRD;
			5:       return HUE_TWO - 1;
			6:       return HUE_TWO;
			7:       return HUE_FULL - HUE_SIXTH;
			8:       return HUE_FULL;
			9:       return HUE_FULL + 1;
			10:      return 8191;
			default: return HUE_TWO + HUE_SIXTH;
		endcase
	endfunction

	// Q1.8 values around zero, one half, one and the top of the field.
	function automatic int q18_edge();
		case ($urandom_range(0, 8))
			0:       return 0;
			1:       return 1;
			2:       return HALF_Q8 - 1;
			3:       return HALF_Q8;
			4:       return HALF_Q8 + 1;
			5:       return UNIT_Q8 - 1;
			6:       return UNIT_Q8;
			7:       return UNIT_Q8 + 1;
			default: return 511;
		endcase
	endfunction

	// Input driver: holds a word until it is taken, then moves on or inserts a gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsl_valid <= 1'b0;
			send_gap  <= 0;
		end else begin
			if (hsl_valid && !hsl_stall)
				rgb_expected.push_back(hsl_to_levels('{hue, saturation, lightness}));
			if (!hsl_valid || !hsl_stall) begin
				if (send_gap != 0 && hsl_pending.size() > TailWords) begin
					hsl_valid <= 1'b0;
					send_gap  <= send_gap - 1;
				end else if (hsl_pending.size() != 0) begin
					next_word  = hsl_pending.pop_front();
					hsl_valid  <= 1'b1;
					hue        <= next_word.hue;
					saturation <= next_word.saturation;
					lightness  <= next_word.lightness;
					if (hsl_pending.size() > TailWords && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(1, 11);
					else
						send_gap <= 0;
				end else begin
					hsl_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each taken word and throttles the core with stall bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_stall <= 1'b0;
			recv_hold <= 0;
		end else begin
			if (rgb_valid && !rgb_stall) begin
				seen_rgb = '{red_level, green_level, blue_level};
				if (rgb_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected word r=%0d g=%0d b=%0d",
						seen_rgb.red, seen_rgb.green, seen_rgb.blue));
				end else begin
					want_rgb = rgb_expected.pop_front();
					if (seen_rgb != want_rgb)
						report_mismatch($sformatf(
							"expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							want_rgb.red, want_rgb.green, want_rgb.blue,
							seen_rgb.red, seen_rgb.green, seen_rgb.blue));
				end
			end
			if (recv_hold != 0 && hsl_pending.size() > TailWords) begin
				rgb_stall <= 1'b1;
				recv_hold <= recv_hold - 1;
			end else begin
				rgb_stall <= 1'b0;
				if (hsl_pending.size() > TailWords && $urandom_range(0, 7) == 0)
					recv_hold <= $urandom_range(1, 11);
				else
					recv_hold <= 0;
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// Directed words: sector edges, clamp edges, hue wrap, Q1.8 extremes.
		queue_hsl(0, 256, 128);
		queue_hsl(HUE_SIXTH - 1, 256, 128);
		queue_hsl(HUE_SIXTH, 256, 128);
		queue_hsl(HUE_THIRD - 1, 256, 128);
		queue_hsl(HUE_THIRD, 256, 128);
		queue_hsl(HUE_TWO - 1, 256, 128);
		queue_hsl(HUE_TWO, 256, 128);
		queue_hsl(HUE_FULL, 256, 128);
		queue_hsl(HUE_FULL + 1, 256, 128);
		queue_hsl(8191, 256, 128);
		queue_hsl(4096, 0, 0);
		queue_hsl(4096, 0, 256);
		queue_hsl(1000, 256, 127);
		queue_hsl(1000, 256, 129);
		queue_hsl(2500, 128, 64);
		queue_hsl(2500, 128, 200);
		queue_hsl(300, 511, 128);
		queue_hsl(300, 511, 511);
		queue_hsl(5000, 511, 64);
		queue_hsl(5000, 300, 300);
		queue_hsl(3000, 0, 511);
		queue_hsl(7000, 511, 0);
		queue_hsl(8191, 511, 511);
		// Random words: mostly in the nominal range, some edges, some anywhere in the fields.
		repeat (RandomWords) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6:
					queue_hsl($urandom_range(0, HUE_FULL), $urandom_range(0, UNIT_Q8),
						$urandom_range(0, UNIT_Q8));
				7, 8:
					queue_hsl(hue_edge(), q18_edge(), q18_edge());
				default:
					queue_hsl($urandom_range(0, 8191), $urandom_range(0, 511),
						$urandom_range(0, 511));
			endcase
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (hsl_pending.size() != 0 || hsl_valid)
			@(posedge clk);
		while (rgb_expected.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### hsl_to_rgb_converter_core.f
src/h2r_pkg.sv
src/h2r_channel.sv
src/hsl_to_rgb_converter_core.sv
tb/sv/hsl_to_rgb_converter_core_tb.sv
